FILE: hdl/cfr_pkg.sv
// Shared types and constants for the command frame receiver.
// No dependencies; imported by every module of the block.
package cfr_pkg;

  localparam int DEFAULT_PAYLOAD_DEPTH = 256;

  localparam logic [7:0] MIN_LENGTH = 8'h06;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [7:0] {
    REG_SYNC_FIRST  = 8'd0,
    REG_SYNC_SECOND = 8'd1
  } reg_index_t;

  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_LEN     = 4'd2,
    PH_HW_LO   = 4'd3,
    PH_HW_HI   = 4'd4,
    PH_MSG_LO  = 4'd5,
    PH_MSG_HI  = 4'd6,
    PH_DEST    = 4'd7,
    PH_CODE    = 4'd8,
    PH_PAYLOAD = 4'd9,
    PH_DONE    = 4'd10
  } phase_t;

  typedef struct packed {
    logic        complete;
    logic [3:0]  phase;
    logic [7:0]  length;
    logic [15:0] hw_id;
    logic [15:0] msg_id;
    logic [7:0]  dest;
    logic [7:0]  code;
  } frame_status_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } store_write_t;

endpackage

FILE: hdl/command_frame_receiver.sv
// Command frame receiver top level: ports, sync registers, submodule wiring.
// Depends on cfr_pkg, cfr_parser, cfr_payload_store and cfr_result_pipe.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per item: opcode,
//   rx_byte and payload_index. Push feeds one serial byte to the parser,
//   read fetches a stored payload byte, clear drops the frame.
//   Output channel (out_valid/out_ready) returns one word per input word,
//   in order: the parser state after that item plus the payload byte read.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes the two
//   sync byte values; write it only while no item is in flight.
// Timing:
//   An accepted word passes the read stage and then the output register
//   before out_valid rises. One word per cycle is sustained while out_ready
//   stays high; the payload memory's registered read sets the extra stage.
// Reset:
//   rst clears the parser, the sync registers and both pipeline valids.
//   Payload memory is not cleared; reads beyond the received count give 0.
// Stalls:
//   With out_ready low the output register holds its word, the read stage
//   fills, and then in_ready drops until the output drains.
module command_frame_receiver
  import cfr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // input word channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  payload_index,
  // result word channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        frame_complete,
  output logic [3:0]  parse_phase,
  output logic [7:0]  frame_length,
  output logic [15:0] hardware_id,
  output logic [15:0] message_id,
  output logic [7:0]  destination_id,
  output logic [7:0]  command_code,
  output logic [7:0]  payload_byte
);

  logic          in_fire;
  logic          stage_free;
  logic [7:0]    sync_first;
  logic [7:0]    sync_second;
  frame_status_t status;
  frame_status_t out_status;
  store_write_t  wr;
  logic          rd_hit;
  logic [7:0]    rd_data;

  // Config writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= 8'd0;
      sync_second <= 8'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first  <= cfg_data;
        REG_SYNC_SECOND: sync_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Accept a word whenever the read stage is empty or moves on this cycle.
  assign in_ready = stage_free;
  assign in_fire  = in_valid && in_ready;

  cfr_parser #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_fire),
    .opcode       (opcode),
    .rx_byte      (rx_byte),
    .payload_index(payload_index),
    .sync_first   (sync_first),
    .sync_second  (sync_second),
    .status       (status),
    .wr           (wr),
    .rd_hit       (rd_hit)
  );

  // Read on every accepted word so the data register tracks the read stage.
  cfr_payload_store #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (in_fire),
    .rd_index(payload_index),
    .rd_data (rd_data)
  );

  // Parser registers hold the post-item state until the next accept, which
  // cannot happen before the read stage hands its word to the output.
  cfr_result_pipe u_result (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_fire),
    .rd_hit    (rd_hit),
    .status    (status),
    .rd_data   (rd_data),
    .stage_free(stage_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_byte  (payload_byte)
  );

  assign frame_complete = out_status.complete;
  assign parse_phase    = out_status.phase;
  assign frame_length   = out_status.length;
  assign hardware_id    = out_status.hw_id;
  assign message_id     = out_status.msg_id;
  assign destination_id = out_status.dest;
  assign command_code   = out_status.code;

endmodule

FILE: hdl/cfr_parser.sv
// Frame parser: phase register, header registers and payload counters.
// Depends on cfr_pkg; drives the payload store write port.
module cfr_parser
  import cfr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [1:0]    opcode,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    payload_index,
  input  logic [7:0]    sync_first,
  input  logic [7:0]    sync_second,
  output frame_status_t status,
  output store_write_t  wr,
  output logic          rd_hit
);

  phase_t      phase, phase_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [7:0]  payload_expected, payload_expected_next;
  logic [7:0]  length_reg, length_reg_next;
  logic [15:0] hw_id_reg, hw_id_reg_next;
  logic [15:0] msg_id_reg, msg_id_reg_next;
  logic [15:0] dest_and_code_reg, dest_and_code_reg_next;
  logic [7:0]  count_inc;
  logic        fits_store;

  assign count_inc  = payload_count + 8'd1;
  assign fits_store = {1'b0, payload_count} < 9'(PAYLOAD_DEPTH);

  always_comb begin
    phase_next             = phase;
    payload_count_next     = payload_count;
    payload_expected_next  = payload_expected;
    length_reg_next        = length_reg;
    hw_id_reg_next         = hw_id_reg;
    msg_id_reg_next        = msg_id_reg;
    dest_and_code_reg_next = dest_and_code_reg;
    wr.en                  = 1'b0;
    wr.addr                = payload_count;
    wr.data                = rx_byte;

    if (opcode == OP_CLEAR) begin
      phase_next             = PH_SYNC1;
      payload_count_next     = '0;
      payload_expected_next  = '0;
      length_reg_next        = '0;
      hw_id_reg_next         = '0;
      msg_id_reg_next        = '0;
      dest_and_code_reg_next = '0;
    end else if (opcode == OP_PUSH) begin
      unique case (phase)
        PH_SYNC1: begin
          if (rx_byte == sync_first) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          // a bad second sync drops the frame; the byte is not retried
          if (rx_byte == sync_second) begin
            phase_next = PH_LEN;
          end else begin
            phase_next             = PH_SYNC1;
            payload_count_next     = '0;
            payload_expected_next  = '0;
            length_reg_next        = '0;
            hw_id_reg_next         = '0;
            msg_id_reg_next        = '0;
            dest_and_code_reg_next = '0;
          end
        end
        PH_LEN: begin
          if (rx_byte >= MIN_LENGTH) begin
            length_reg_next       = rx_byte;
            payload_count_next    = '0;
            payload_expected_next = rx_byte - MIN_LENGTH;
            phase_next            = PH_HW_LO;
          end else begin
            phase_next             = PH_SYNC1;
            payload_count_next     = '0;
            payload_expected_next  = '0;
            length_reg_next        = '0;
            hw_id_reg_next         = '0;
            msg_id_reg_next        = '0;
            dest_and_code_reg_next = '0;
          end
        end
        PH_HW_LO: begin
          hw_id_reg_next[7:0] = rx_byte;
          phase_next          = PH_HW_HI;
        end
        PH_HW_HI: begin
          hw_id_reg_next[15:8] = rx_byte;
          phase_next           = PH_MSG_LO;
        end
        PH_MSG_LO: begin
          msg_id_reg_next[7:0] = rx_byte;
          phase_next           = PH_MSG_HI;
        end
        PH_MSG_HI: begin
          msg_id_reg_next[15:8] = rx_byte;
          phase_next            = PH_DEST;
        end
        PH_DEST: begin
          dest_and_code_reg_next[15:8] = rx_byte;
          phase_next                   = PH_CODE;
        end
        PH_CODE: begin
          dest_and_code_reg_next[7:0] = rx_byte;
          phase_next = (payload_count < payload_expected) ? PH_PAYLOAD : PH_DONE;
        end
        PH_PAYLOAD: begin
          if (payload_count < payload_expected) begin
            wr.en              = fits_store;
            payload_count_next = count_inc;
            if (count_inc == payload_expected) phase_next = PH_DONE;
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          // frame complete: hold until cleared
        end
      endcase
    end
    wr.en = wr.en && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_SYNC1;
      payload_count     <= '0;
      payload_expected  <= '0;
      length_reg        <= '0;
      hw_id_reg         <= '0;
      msg_id_reg        <= '0;
      dest_and_code_reg <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      payload_count     <= payload_count_next;
      payload_expected  <= payload_expected_next;
      length_reg        <= length_reg_next;
      hw_id_reg         <= hw_id_reg_next;
      msg_id_reg        <= msg_id_reg_next;
      dest_and_code_reg <= dest_and_code_reg_next;
    end
  end

  assign rd_hit = (opcode == OP_READ) && (payload_index < payload_count)
                  && ({1'b0, payload_index} < 9'(PAYLOAD_DEPTH));

  assign status.complete = (phase == PH_DONE);
  assign status.phase    = (phase == PH_DONE) ? PH_PAYLOAD : phase;
  assign status.length   = length_reg;
  assign status.hw_id    = hw_id_reg;
  assign status.msg_id   = msg_id_reg;
  assign status.dest     = dest_and_code_reg[15:8];
  assign status.code     = dest_and_code_reg[7:0];

endmodule

FILE: hdl/cfr_payload_store.sv
// Payload byte memory: one write port, one registered read port.
// Depends on cfr_pkg for the write request type.
module cfr_payload_store
  import cfr_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = DEFAULT_PAYLOAD_DEPTH
) (
  input  logic         clk,
  input  store_write_t wr,
  input  logic         rd_en,
  input  logic [7:0]   rd_index,
  output logic [7:0]   rd_data
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [7:0] mem [PAYLOAD_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr[AW-1:0]] <= wr.data;
    if (rd_en) rd_data <= mem[rd_index[AW-1:0]];
  end

endmodule

FILE: hdl/cfr_result_pipe.sv
// Result path: read-data stage followed by the output register.
// Depends on cfr_pkg for the frame status type.
module cfr_result_pipe
  import cfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          rd_hit,
  input  frame_status_t status,
  input  logic [7:0]    rd_data,
  output logic          stage_free,
  output logic          out_valid,
  input  logic          out_ready,
  output frame_status_t out_status,
  output logic [7:0]    out_byte
);

  logic s1_valid;
  logic s1_hit;
  logic s1_move;

  assign s1_move    = s1_valid && (!out_valid || out_ready);
  assign stage_free = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (s1_move) s1_valid <= 1'b0;
      if (s1_move) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) s1_hit <= rd_hit;
    if (s1_move) begin
      out_status <= status;
      out_byte   <= s1_hit ? rd_data : 8'd0;
    end
  end

endmodule

FILE: hdl/cfr_checker.sv
// Port-level checks for the command frame receiver, bound to the top level.
// Depends on cfr_pkg for phase and length constants.
module cfr_checker
  import cfr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        frame_complete,
  input logic [3:0]  parse_phase,
  input logic [7:0]  frame_length,
  input logic [15:0] hardware_id,
  input logic [15:0] message_id
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(parse_phase)
      && $stable(frame_length) && $stable(hardware_id))
    else $error("stalled result changed");

  a_complete_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_complete |-> parse_phase == PH_PAYLOAD)
    else $error("complete frame without payload phase");

  a_no_length: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_length == 8'd0 |-> parse_phase <= PH_LEN
      && hardware_id == 16'd0 && message_id == 16'd0)
    else $error("header state without accepted length");

  a_length_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_phase >= PH_HW_LO |-> frame_length >= MIN_LENGTH)
    else $error("header phase with short length");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .frame_complete(frame_complete),
  .parse_phase   (parse_phase),
  .frame_length  (frame_length),
  .hardware_id   (hardware_id),
  .message_id    (message_id)
);
